[hw/rtl/gbn_pkg.sv]
// Shared types, constants and helpers for the go-back-N sender window unit.
package gbn_pkg;

  // Fixed field widths
  localparam int SEQ_W = 13;
  localparam int WIN_W = 7;
  localparam int CMD_W = 2;

  // Window limits and reset values
  localparam int                 MAX_WINDOW        = 64;
  localparam logic [WIN_W-1:0]   WINDOW_SIZE_RESET = WIN_W'(10);
  localparam int                 STORE_DEPTH_DEF   = 4096;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ = 2'd0,
    CMD_ACK = 2'd1,
    CMD_TMO = 2'd2,
    CMD_RSV = 2'd3
  } cmd_e;

  // Status of the window walker, one word per cycle while the output takes each word
  typedef struct packed {
    logic emit;   // a sequence number is on offer
    logic empty;  // walk ended with nothing to send
    logic first;  // offered word is the first of the walk
    logic last;   // offered word is the last of the walk
  } walk_stat_t;

  // Clamp the configured window to 1..MAX_WINDOW
  function automatic logic [WIN_W-1:0] eff_window(input logic [WIN_W-1:0] ws);
    logic [WIN_W-1:0] res;
    res = ws;
    if (ws == '0) begin
      res = WIN_W'(1);
    end else if (ws > WIN_W'(MAX_WINDOW)) begin
      res = WIN_W'(MAX_WINDOW);
    end
    return res;
  endfunction

endpackage

[hw/rtl/gbn_walk.sv]
// Window walker: steps one sequence number per cycle through the send window while adv_i is high.
module gbn_walk #(
  parameter int CntW = 13
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [CntW-1:0]          start_idx_i,
  input  logic [CntW-1:0]          qcount_i,
  input  logic [gbn_pkg::WIN_W-1:0] weff_i,
  input  logic                     adv_i,
  output gbn_pkg::walk_stat_t      stat_o,
  output logic [CntW-1:0]          seq_o,
  output logic                     busy_o
);
  import gbn_pkg::*;

  localparam logic [WIN_W-1:0] WinOne = WIN_W'(1);
  localparam logic [CntW-1:0]  IdxOne = CntW'(1);

  logic             busy_q, busy_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [WIN_W-1:0] cnt_q, cnt_d;
  logic             first_q, first_d;
  logic             hit;
  logic             at_end;
  logic [CntW-1:0]  idx_inc;

  // Shared compare unit: index against queue fill and window count
  always_comb begin
    idx_inc      = idx_q + IdxOne;
    hit          = idx_q < qcount_i;
    at_end       = (cnt_q == (weff_i - WinOne)) || (idx_inc >= qcount_i);
    stat_o.emit  = busy_q && hit;
    stat_o.empty = busy_q && !hit;
    stat_o.first = first_q;
    stat_o.last  = at_end;
    seq_o        = idx_inc;
    busy_o       = busy_q;
  end

  // Step sequencer
  always_comb begin
    busy_d  = busy_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    first_d = first_q;
    if (start_i) begin
      busy_d  = 1'b1;
      idx_d   = start_idx_i;
      cnt_d   = '0;
      first_d = 1'b1;
    end else if (stat_o.empty) begin
      busy_d = 1'b0;
    end else if (adv_i) begin
      idx_d   = idx_inc;
      cnt_d   = cnt_q + WinOne;
      first_d = 1'b0;
      if (at_end) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      first_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      first_q <= first_d;
    end
  end

  // Index and count need no reset: loaded on start
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    cnt_q <= cnt_d;
  end

endmodule

[hw/rtl/go_back_n_sender_window_unit.sv]
// Go-back-N sender window control: command decode, window state, result register.
// Each command word is decoded in ST_EXEC; the window walker then offers one sequence number per
// cycle while the receiver takes them. An overflow word, or the flag after an empty end-of-message
// walk, goes out from ST_SINGLE. One command word at a time: ready again once back in idle.
// Reset: async active low; counters, left edge and max sent go to 0, window to 10.
module go_back_n_sender_window_unit #(
  parameter int StoreDepth = gbn_pkg::STORE_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_we_i,
  input  logic [gbn_pkg::WIN_W-1:0] cfg_wdata_i,
  // input channel
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [gbn_pkg::CMD_W-1:0] cmd_i,
  input  logic                      end_of_message_i,
  input  logic [gbn_pkg::SEQ_W-1:0] ack_seq_i,
  input  logic                      ack_ok_i,
  // output channel
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      send_valid_o,
  output logic [gbn_pkg::SEQ_W-1:0] send_seq_o,
  output logic                      start_timer_o,
  output logic                      overflow_o,
  output logic                      last_o
);
  import gbn_pkg::*;

  localparam int CntRaw = $clog2(StoreDepth + 1);
  localparam int CntW   = (CntRaw > SEQ_W) ? CntRaw : SEQ_W;
  localparam logic [CntW-1:0] CntOne  = CntW'(1);
  localparam logic [CntW-1:0] DepthCw = CntW'(StoreDepth);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EXEC   = 4'b0010,
    ST_WALK   = 4'b0100,
    ST_SINGLE = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [WIN_W-1:0] win_q;
  logic [CntW-1:0]  qc_q, qc_d;
  logic [CntW-1:0]  left_q, left_d;
  logic [CntW-1:0]  max_q, max_d;

  // latched command word
  cmd_e             cmd_q;
  logic             eom_q;
  logic [SEQ_W-1:0] ack_q;
  logic             ok_q;

  logic             ovf_q, ovf_d;
  logic             tf_q, tf_d;

  // walker interface
  logic             walk_start;
  logic [CntW-1:0]  walk_idx;
  walk_stat_t       walk_stat;
  logic [CntW-1:0]  walk_seq;
  logic             walk_busy;

  // result register
  logic             out_valid_q, out_valid_d;
  logic             out_load;
  logic             out_free;
  logic             o_sv_q, o_sv_d;
  logic [SEQ_W-1:0] o_seq_q, o_seq_d;
  logic             o_tmr_q, o_tmr_d;
  logic             o_ovf_q, o_ovf_d;
  logic             o_last_q, o_last_d;

  logic [CntW-1:0]  ack_x;
  logic             full;
  logic             ack_take;

  gbn_walk #(
    .CntW (CntW)
  ) u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (walk_start),
    .start_idx_i (walk_idx),
    .qcount_i    (qc_q),
    .weff_i      (eff_window(win_q)),
    .adv_i       (out_load),
    .stat_o      (walk_stat),
    .seq_o       (walk_seq),
    .busy_o      (walk_busy)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  // Decode, update window state, and route results into the output register
  always_comb begin
    state_d    = state_q;
    qc_d       = qc_q;
    left_d     = left_q;
    max_d      = max_q;
    ovf_d      = ovf_q;
    tf_d       = tf_q;
    walk_start = 1'b0;
    walk_idx   = left_q;
    out_load   = 1'b0;
    o_sv_d     = 1'b0;
    o_seq_d    = '0;
    o_tmr_d    = 1'b0;
    o_ovf_d    = 1'b0;
    o_last_d   = 1'b0;

    ack_x    = CntW'(ack_q);
    full     = qc_q >= DepthCw;
    ack_take = ok_q && (ack_x > left_q) && (ack_x <= qc_q);

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ovf_d   = (cmd_q == CMD_ENQ) && full;
        state_d = ST_IDLE;
        case (cmd_q)
          CMD_ENQ: begin
            if (!full) begin
              qc_d = qc_q + CntOne;
            end
            if (eom_q) begin
              walk_start = 1'b1;
              tf_d       = 1'b0;
              state_d    = ST_WALK;
            end else if (full) begin
              state_d = ST_SINGLE;
            end
          end
          CMD_ACK: begin
            if (ack_take) begin
              left_d = ack_x;
              if (ack_x > max_q) begin
                walk_start = 1'b1;
                walk_idx   = ack_x;
                tf_d       = 1'b1;
                state_d    = ST_WALK;
              end
            end
          end
          CMD_TMO: begin
            walk_start = 1'b1;
            tf_d       = 1'b1;
            state_d    = ST_WALK;
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_WALK: begin
        if (walk_stat.empty) begin
          state_d = (cmd_q == CMD_ENQ) ? ST_SINGLE : ST_IDLE;
        end else if (walk_stat.emit && out_free) begin
          out_load = 1'b1;
          o_sv_d   = 1'b1;
          o_seq_d  = walk_seq[SEQ_W-1:0];
          o_tmr_d  = tf_q ? walk_stat.first : walk_stat.last;
          o_ovf_d  = ovf_q;
          o_last_d = walk_stat.last;
          if (walk_seq > max_q) begin
            max_d = walk_seq;
          end
          if (walk_stat.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SINGLE: begin
        if (out_free) begin
          out_load = 1'b1;
          o_tmr_d  = eom_q;
          o_ovf_d  = ovf_q;
          o_last_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // hold the word until taken
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_q       <= WINDOW_SIZE_RESET;
      qc_q        <= '0;
      left_q      <= '0;
      max_q       <= '0;
      ovf_q       <= 1'b0;
      tf_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      qc_q        <= qc_d;
      left_q      <= left_d;
      max_q       <= max_d;
      ovf_q       <= ovf_d;
      tf_q        <= tf_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        win_q <= cfg_wdata_i;
      end
    end
  end

  // Capture the input word and the result payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= cmd_e'(cmd_i);
      eom_q <= end_of_message_i;
      ack_q <= ack_seq_i;
      ok_q  <= ack_ok_i;
    end
    if (out_load) begin
      o_sv_q   <= o_sv_d;
      o_seq_q  <= o_seq_d;
      o_tmr_q  <= o_tmr_d;
      o_ovf_q  <= o_ovf_d;
      o_last_q <= o_last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign send_valid_o  = o_sv_q;
  assign send_seq_o    = o_seq_q;
  assign start_timer_o = o_tmr_q;
  assign overflow_o    = o_ovf_q;
  assign last_o        = o_last_q;

  // The walker is never running while a new word can be taken
  a_idle_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !walk_busy)
    else $error("walker busy while input is ready");

  // The left edge never passes the queued count
  a_left_le_qc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q <= qc_q)
    else $error("window left edge beyond queued count");

  // Nothing beyond the queued count was ever sent
  a_max_le_qc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    max_q <= qc_q)
    else $error("max sent beyond queued count");

  // The last word of a walk returns the sequencer to idle
  a_last_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && out_load && walk_stat.last) |=> (state_q == ST_IDLE))
    else $error("sequencer did not return to idle after last word");

endmodule

[verif/tb.sv]
// Self-checking testbench for the go-back-N sender window unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gbn_pkg::*;

  // One result word of the output channel
  typedef struct packed {
    logic             send_valid;
    logic [SEQ_W-1:0] send_seq;
    logic             start_timer;
    logic             overflow;
    logic             last;
  } send_word_t;

  // One row of the directed table; typed rows carry their own answer
  typedef struct packed {
    cmd_e             cmd;
    logic             eom;
    logic [SEQ_W-1:0] ack;
    logic             ok;
    logic             typed;
    logic             has_res;
    send_word_t       res;
  } dir_row_t;

  localparam int          NDIR         = 21;
  localparam int          PHASES       = 6;
  localparam int          PHASE_WORDS  = 75;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          SETTLE       = 6;
  localparam send_word_t  NO_SEND      = '0;

  // DUT ports
  logic             clk_i            = 1'b0;
  logic             rst_ni           = 1'b0;
  logic             cfg_we_i         = 1'b0;
  logic [WIN_W-1:0] cfg_wdata_i      = '0;
  logic             in_valid_i       = 1'b0;
  logic             in_ready_o;
  logic [CMD_W-1:0] cmd_i            = '0;
  logic             end_of_message_i = 1'b0;
  logic [SEQ_W-1:0] ack_seq_i        = '0;
  logic             ack_ok_i         = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i      = 1'b0;
  logic             send_valid_o;
  logic [SEQ_W-1:0] send_seq_o;
  logic             start_timer_o;
  logic             overflow_o;
  logic             last_o;

  // Window model state
  logic [WIN_W-1:0] model_win      = WINDOW_SIZE_RESET;
  int unsigned      model_queued   = 0;
  int unsigned      model_left     = 0;
  int unsigned      model_max_sent = 0;

  send_word_t step_sends[$];
  send_word_t sends_due[$];

  int send_errors = 0;
  int words_in    = 0;
  int words_out   = 0;
  int send_idle   = 0;
  int recv_idle   = 0;
  int hold_asks   = 0;
  int hold_served = 0;
  int hold_left   = 0;

  int unsigned phase_wins [PHASES] = '{0, 127, 64, 1, 37, 5};

  // Directed rows, starting from the reset window of 10
  dir_row_t dir_tab [NDIR] = '{
    '{CMD_TMO, 1'b0, 13'd0,    1'b0, 1'b1, 1'b0, NO_SEND},
    '{CMD_ACK, 1'b0, 13'd0,    1'b1, 1'b1, 1'b0, NO_SEND},
    '{CMD_ENQ, 1'b1, 13'd8191, 1'b1, 1'b1, 1'b1, send_word_t'{1'b1, 13'd1, 1'b1, 1'b0, 1'b1}},
    '{CMD_ENQ, 1'b0, 13'd0,    1'b0, 1'b1, 1'b0, NO_SEND},
    '{CMD_ENQ, 1'b0, 13'd4096, 1'b1, 1'b1, 1'b0, NO_SEND},
    '{CMD_ENQ, 1'b0, 13'd0,    1'b0, 1'b1, 1'b0, NO_SEND},
    '{CMD_ENQ, 1'b1, 13'd0,    1'b0, 1'b0, 1'b0, NO_SEND},
    '{CMD_ACK, 1'b0, 13'd3,    1'b0, 1'b1, 1'b0, NO_SEND},
    '{CMD_ACK, 1'b0, 13'd6,    1'b1, 1'b1, 1'b0, NO_SEND},
    '{CMD_ACK, 1'b0, 13'd8191, 1'b1, 1'b1, 1'b0, NO_SEND},
    '{CMD_ACK, 1'b0, 13'd3,    1'b1, 1'b1, 1'b0, NO_SEND},
    '{CMD_TMO, 1'b0, 13'd0,    1'b0, 1'b0, 1'b0, NO_SEND},
    '{CMD_RSV, 1'b1, 13'd8191, 1'b1, 1'b1, 1'b0, NO_SEND},
    '{CMD_ENQ, 1'b0, 13'd0,    1'b0, 1'b1, 1'b0, NO_SEND},
    '{CMD_ENQ, 1'b0, 13'd0,    1'b0, 1'b1, 1'b0, NO_SEND},
    '{CMD_ENQ, 1'b0, 13'd0,    1'b0, 1'b1, 1'b0, NO_SEND},
    '{CMD_ACK, 1'b0, 13'd7,    1'b1, 1'b1, 1'b1, send_word_t'{1'b1, 13'd8, 1'b1, 1'b0, 1'b1}},
    '{CMD_ACK, 1'b0, 13'd7,    1'b1, 1'b1, 1'b0, NO_SEND},
    '{CMD_ACK, 1'b0, 13'd8,    1'b1, 1'b1, 1'b0, NO_SEND},
    '{CMD_TMO, 1'b0, 13'd0,    1'b0, 1'b1, 1'b0, NO_SEND},
    '{CMD_ENQ, 1'b1, 13'd0,    1'b0, 1'b1, 1'b1, send_word_t'{1'b1, 13'd9, 1'b1, 1'b0, 1'b1}}
  };

  go_back_n_sender_window_unit #(
    .StoreDepth(STORE_DEPTH_DEF)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .end_of_message_i (end_of_message_i),
    .ack_seq_i        (ack_seq_i),
    .ack_ok_i         (ack_ok_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .send_valid_o     (send_valid_o),
    .send_seq_o       (send_seq_o),
    .start_timer_o    (start_timer_o),
    .overflow_o       (overflow_o),
    .last_o           (last_o)
  );

  always #1 clk_i = ~clk_i;

  // Clamp the configured window the way the block reads it
  function automatic int unsigned window_span();
    int unsigned span;
    span = model_win;
    if (model_win == '0) begin
      span = 1;
    end else if (model_win > WIN_W'(MAX_WINDOW)) begin
      span = MAX_WINDOW;
    end
    return span;
  endfunction

  // Walk the window from its left edge and queue one word per packet
  task automatic walk_window(input bit timer_first, input logic ovf);
    int unsigned span;
    int unsigned idx;
    int unsigned k;
    int          n;
    span = window_span();
    n = 0;
    for (k = 0; k < span; k++) begin
      idx = model_left + k;
      if (idx >= model_queued) break;
      step_sends.insert(step_sends.size(),
                        send_word_t'{1'b1, SEQ_W'(idx + 1), timer_first && n == 0,
                                     ovf, 1'b0});
      if (idx + 1 > model_max_sent) model_max_sent = idx + 1;
      n++;
    end
    if (!timer_first && n > 0) step_sends[n-1].start_timer = 1'b1;
  endtask

  // Advance the window state by one command and collect the words it sends
  task automatic predict_sends(input cmd_e c, input logic e, input logic [SEQ_W-1:0] a,
                               input logic k);
    logic ovf;
    step_sends.delete();
    ovf = 1'b0;
    case (c)
      CMD_ENQ: begin
        if (model_queued < STORE_DEPTH_DEF) model_queued++;
        else ovf = 1'b1;
        if (e) begin
          walk_window(1'b0, ovf);
          if (step_sends.size() == 0)
            step_sends.insert(0, send_word_t'{1'b0, '0, 1'b1, ovf, 1'b0});
        end else if (ovf) begin
          step_sends.insert(0, send_word_t'{1'b0, '0, 1'b0, 1'b1, 1'b0});
        end
      end
      CMD_ACK: begin
        if (k && a > model_left && a <= model_queued) begin
          model_left = a;
          if (model_left > model_max_sent) walk_window(1'b1, 1'b0);
        end
      end
      CMD_TMO: begin
        walk_window(1'b1, 1'b0);
      end
      default: ;
    endcase
    if (step_sends.size() > 0) step_sends[step_sends.size()-1].last = 1'b1;
  endtask

  task automatic flag_send_error(input string what);
    send_errors++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Offer one word and hold it until the block takes it
  task automatic put_word(input cmd_e c, input logic e, input logic [SEQ_W-1:0] a,
                          input logic k, input bit typed, input bit has_res,
                          input send_word_t res);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    predict_sends(c, e, a, k);
    if (typed) begin
      if (has_res) sends_due.insert(sends_due.size(), res);
    end else begin
      foreach (step_sends[n]) sends_due.insert(sends_due.size(), step_sends[n]);
    end
    in_valid_i       <= 1'b1;
    cmd_i            <= c;
    end_of_message_i <= e;
    ack_seq_i        <= a;
    ack_ok_i         <= k;
    words_in++;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Mostly well-formed traffic: enqueues, ACKs near the window, timeouts
  task automatic random_word();
    cmd_e             c;
    logic             e;
    logic [SEQ_W-1:0] a;
    logic             k;
    int unsigned      r;
    e = ($urandom_range(9) < 3);
    a = SEQ_W'($urandom);
    k = ($urandom_range(9) != 0);
    r = $urandom_range(99);
    if (r < 50) begin
      c = CMD_ENQ;
    end else if (r < 80) begin
      c = CMD_ACK;
      r = $urandom_range(99);
      if (r < 60) a = SEQ_W'(model_left + $urandom_range(window_span() + 2, 1));
      else if (r < 80) a = SEQ_W'($urandom_range(model_queued + 1, 0));
    end else if (r < 95) begin
      c = CMD_TMO;
    end else begin
      c = CMD_RSV;
    end
    put_word(c, e, a, k, 1'b0, 1'b0, NO_SEND);
  endtask

  // Drop valid and wait until every due word is back
  task automatic drain(input int settle);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sends_due.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic set_window(input int unsigned v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= WIN_W'(v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    model_win = WIN_W'(v);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle = 34; recv_idle = 57; end
      1: begin send_idle = 57; recv_idle = 34; end
      default: begin send_idle = 0; recv_idle = 0; end
    endcase
  endtask

  // Output side: check each taken word, then pick the next ready
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_out++;
      if (sends_due.size() == 0) begin
        flag_send_error($sformatf("word seq %0d with nothing due", send_seq_o));
      end else begin
        if (send_valid_o !== sends_due[0].send_valid)
          flag_send_error($sformatf("send_valid %b, want %b", send_valid_o,
                                    sends_due[0].send_valid));
        if (send_seq_o !== sends_due[0].send_seq)
          flag_send_error($sformatf("send_seq %0d, want %0d", send_seq_o,
                                    sends_due[0].send_seq));
        if (start_timer_o !== sends_due[0].start_timer)
          flag_send_error($sformatf("start_timer %b, want %b at seq %0d", start_timer_o,
                                    sends_due[0].start_timer, sends_due[0].send_seq));
        if (overflow_o !== sends_due[0].overflow)
          flag_send_error($sformatf("overflow %b, want %b", overflow_o,
                                    sends_due[0].overflow));
        if (last_o !== sends_due[0].last)
          flag_send_error($sformatf("last %b, want %b at seq %0d", last_o,
                                    sends_due[0].last, sends_due[0].send_seq));
        void'(sends_due.pop_front());
      end
    end
    // Start a long hold when asked, otherwise stall at random
    if (hold_served != hold_asks) begin
      hold_served = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Stimulus
  initial begin
    int i;
    int ph;
    int j;
    set_idling(0);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    for (i = 0; i < NDIR; i++) begin
      put_word(dir_tab[i].cmd, dir_tab[i].eom, dir_tab[i].ack, dir_tab[i].ok,
               dir_tab[i].typed, dir_tab[i].has_res, dir_tab[i].res);
    end

    // Random phases over several window settings and idling mixes
    for (ph = 0; ph < PHASES; ph++) begin
      drain(SETTLE);
      set_window(phase_wins[ph]);
      set_idling(ph / 2);
      if (ph == 2) hold_asks++;
      for (j = 0; j < PHASE_WORDS; j++) begin
        if (ph == 3 && j == PHASE_WORDS / 2) drain(0);
        random_word();
      end
    end

    // Close with edge words: ACKs at and past the store depth, reserved command
    drain(SETTLE);
    set_window(MAX_WINDOW);
    set_idling(0);
    put_word(CMD_ENQ, 1'b1, '0, 1'b0, 1'b0, 1'b0, NO_SEND);
    put_word(CMD_ENQ, 1'b0, '0, 1'b0, 1'b0, 1'b0, NO_SEND);
    put_word(CMD_ACK, 1'b0, SEQ_W'(STORE_DEPTH_DEF), 1'b1, 1'b0, 1'b0, NO_SEND);
    put_word(CMD_ENQ, 1'b1, '0, 1'b1, 1'b0, 1'b0, NO_SEND);
    put_word(CMD_TMO, 1'b0, '0, 1'b0, 1'b0, 1'b0, NO_SEND);
    put_word(CMD_ACK, 1'b0, SEQ_W'(STORE_DEPTH_DEF + 1), 1'b1, 1'b0, 1'b0, NO_SEND);
    put_word(CMD_RSV, 1'b1, '1, 1'b1, 1'b0, 1'b0, NO_SEND);

    drain(SETTLE * 2);
    $display("covered %0d input words, %0d result words, windows 0 to 127,",
             words_in, words_out);
    $display("a long receiver hold and ACKs past the queue; mismatches seen: %0d",
             send_errors);
    if (send_errors == 0) begin
      $display("go_back_n_sender_window_unit regression: pass");
    end else begin
      $display("go_back_n_sender_window_unit regression: fail");
    end
    $finish;
  end

  // Give up after a generous bound
  initial begin
    #2_000_000;
    $display("timeout with %0d words still due", sends_due.size());
    $display("go_back_n_sender_window_unit regression: fail");
    $finish;
  end

endmodule
